// File: hdl/ile_pkg.sv
`timescale 1ns / 1ps

package ile_pkg;

  localparam int DEPTH      = 64;
  localparam int ENTRY_BITS = 32;
  localparam int IDX_BITS   = $clog2(DEPTH);
  localparam int POS_BITS   = 7;
  localparam int CNT_BITS   = 7;
  localparam int ACT_BITS   = 3;
  localparam int ST_BITS    = 2;
  localparam int CFG_BITS   = 7;

  localparam logic [ACT_BITS-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_BITS-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACT_BITS-1:0] ACT_GET    = 3'd2;
  localparam logic [ACT_BITS-1:0] ACT_SET    = 3'd3;
  localparam logic [ACT_BITS-1:0] ACT_PUSH   = 3'd4;
  localparam logic [ACT_BITS-1:0] ACT_POP    = 3'd5;

  localparam logic [ST_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [ST_BITS-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_BITS-1:0] ST_FULL  = 2'd2;

  localparam logic CFG_INIT_CAP = 1'b0;
  localparam logic CFG_GROWTH   = 1'b1;

  localparam logic [CFG_BITS-1:0] INIT_CAP_RESET = 7'd8;
  localparam logic [CFG_BITS-1:0] GROWTH_RESET   = 7'd8;

  // broadcast to every cell; at most one of ins/rem/set is high
  typedef struct packed {
    logic                  ins;
    logic                  rem;
    logic                  set;
    logic [POS_BITS-1:0]   pos;
    logic [ENTRY_BITS-1:0] val;
  } ile_cmd_t;

endpackage

// File: hdl/ile_cell.sv
`timescale 1ns / 1ps

module ile_cell (
  input  logic                              clk,
  input  ile_pkg::ile_cmd_t                 cmd,
  input  logic [ile_pkg::IDX_BITS-1:0]      index,
  input  logic [ile_pkg::ENTRY_BITS-1:0]    left,
  input  logic [ile_pkg::ENTRY_BITS-1:0]    right,
  output logic [ile_pkg::ENTRY_BITS-1:0]    data
);

  logic [ile_pkg::POS_BITS-1:0]   idx_ext;
  logic [ile_pkg::ENTRY_BITS-1:0] data_next;
  logic                           at_pos;
  logic                           above_pos;

  assign idx_ext   = {{(ile_pkg::POS_BITS - ile_pkg::IDX_BITS){1'b0}}, index};
  assign at_pos    = idx_ext == cmd.pos;
  assign above_pos = idx_ext > cmd.pos;

  always_comb begin
    priority if ((cmd.ins || cmd.set) && at_pos) begin
      data_next = cmd.val;
    end else if (cmd.ins && above_pos) begin
      data_next = left;
    end else if (cmd.rem && (above_pos || at_pos)) begin
      data_next = right;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// File: hdl/indexed_list_engine_unit.sv
`timescale 1ns / 1ps
// A result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while the result side is not stalled by m_tready;
// every cell shifts, loads or holds in the same cycle, and the read at the position is one selection over the cells.
// Reset (rst, synchronous): list empty, initial_capacity and growth_step 8,
// no result pending. Entry contents are not cleared.
module indexed_list_engine_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [47:0]                      s_tdata,  // action, position, entry_value, pad
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [47:0]                      m_tdata,  // value_out, status, list_length, is_empty, pad
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [ile_pkg::CFG_BITS-1:0]     cfg_wdata
);

  logic [ile_pkg::ACT_BITS-1:0]   action;
  logic [ile_pkg::POS_BITS-1:0]   position;
  logic [ile_pkg::ENTRY_BITS-1:0] entry_value;

  logic [ile_pkg::CFG_BITS-1:0]   initial_capacity;
  logic [ile_pkg::CFG_BITS-1:0]   growth_step;
  logic [ile_pkg::CNT_BITS-1:0]   count;
  logic [ile_pkg::CNT_BITS-1:0]   count_next;
  logic [ile_pkg::CNT_BITS-1:0]   cap;

  logic [ile_pkg::ENTRY_BITS-1:0] value_out;
  logic [ile_pkg::ST_BITS-1:0]    status;
  logic [ile_pkg::ENTRY_BITS-1:0] value_next;
  logic [ile_pkg::ST_BITS-1:0]    status_next;
  logic                           out_valid;

  logic                           accept;
  logic                           is_ins;
  logic                           is_rem;
  logic                           is_get;
  logic                           is_set;
  logic [ile_pkg::POS_BITS-1:0]   eff_pos;
  logic                           range_ins;
  logic                           range_idx;
  logic                           full;
  logic [ile_pkg::ENTRY_BITS-1:0] rd_data;
  ile_pkg::ile_cmd_t              cmd;

  logic [ile_pkg::ENTRY_BITS-1:0] cell_data  [ile_pkg::DEPTH];
  logic [ile_pkg::ENTRY_BITS-1:0] left_data  [ile_pkg::DEPTH];
  logic [ile_pkg::ENTRY_BITS-1:0] right_data [ile_pkg::DEPTH];

  assign action      = s_tdata[2:0];
  assign position    = s_tdata[9:3];
  assign entry_value = s_tdata[41:10];

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    if (growth_step != '0) begin
      cap = ile_pkg::CNT_BITS'(ile_pkg::DEPTH);
    end else if (initial_capacity > ile_pkg::CNT_BITS'(ile_pkg::DEPTH)) begin
      cap = ile_pkg::CNT_BITS'(ile_pkg::DEPTH);
    end else begin
      cap = initial_capacity;
    end
  end

  assign is_ins = (action == ile_pkg::ACT_INSERT) || (action == ile_pkg::ACT_PUSH);
  assign is_rem = (action == ile_pkg::ACT_REMOVE) || (action == ile_pkg::ACT_POP);
  assign is_get = action == ile_pkg::ACT_GET;
  assign is_set = action == ile_pkg::ACT_SET;

  always_comb begin
    unique case (action)
      ile_pkg::ACT_PUSH: eff_pos = count;
      ile_pkg::ACT_POP:  eff_pos = count - 1'b1;
      default:           eff_pos = position;
    endcase
  end

  assign range_ins = eff_pos > count;
  assign range_idx = (eff_pos >= count) || (count == '0);
  assign full      = count >= cap;
  assign rd_data   = cell_data[eff_pos[ile_pkg::IDX_BITS-1:0]];

  always_comb begin
    count_next  = count;
    status_next = ile_pkg::ST_OK;
    value_next  = '0;
    cmd.ins     = 1'b0;
    cmd.rem     = 1'b0;
    cmd.set     = 1'b0;
    cmd.pos     = eff_pos;
    cmd.val     = entry_value;
    priority if (is_ins) begin
      if (range_ins) begin
        status_next = ile_pkg::ST_RANGE;
      end else if (full) begin
        status_next = ile_pkg::ST_FULL;
      end else begin
        cmd.ins    = accept;
        count_next = count + 1'b1;
        value_next = entry_value;
      end
    end else if (is_rem || is_get || is_set) begin
      if (range_idx) begin
        status_next = ile_pkg::ST_RANGE;
      end else if (is_rem) begin
        cmd.rem    = accept;
        count_next = count - 1'b1;
        value_next = rd_data;
      end else if (is_set) begin
        cmd.set    = accept;
        value_next = entry_value;
      end else begin
        value_next = rd_data;
      end
    end else begin
      status_next = ile_pkg::ST_OK;
    end
  end

  for (genvar g = 0; g < ile_pkg::DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_data[g] = '0;
    end else begin : g_mid_l
      assign left_data[g] = cell_data[g-1];
    end
    if (g == ile_pkg::DEPTH - 1) begin : g_last
      assign right_data[g] = cell_data[g];
    end else begin : g_mid_r
      assign right_data[g] = cell_data[g+1];
    end
    ile_cell u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .index (ile_pkg::IDX_BITS'(g)),
      .left  (left_data[g]),
      .right (right_data[g]),
      .data  (cell_data[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_capacity <= ile_pkg::INIT_CAP_RESET;
      growth_step      <= ile_pkg::GROWTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ile_pkg::CFG_INIT_CAP: initial_capacity <= cfg_wdata;
        ile_pkg::CFG_GROWTH:   growth_step      <= cfg_wdata;
        default:               growth_step      <= growth_step;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_out <= value_next;
      status    <= status_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, (count == '0), count, status, value_out};

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ile_pkg::*;

  // action codes the block ignores
  localparam logic [ACT_BITS-1:0] ACT_NOP6 = 3'd6;
  localparam logic [ACT_BITS-1:0] ACT_NOP7 = 3'd7;

  typedef struct packed {
    logic [ENTRY_BITS-1:0] value;
    logic [ST_BITS-1:0]    status;
    logic [CNT_BITS-1:0]   length;
    logic                  empty;
  } list_result_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [47:0]         s_tdata;  // action, position, entry_value, pad
  logic                m_tvalid;
  logic                m_tready;
  logic [47:0]         m_tdata;  // value_out, status, list_length, is_empty, pad
  logic                cfg_we;
  logic                cfg_index;
  logic [CFG_BITS-1:0] cfg_wdata;

  // shadow of the list and its registers
  logic [ENTRY_BITS-1:0] list_mem [DEPTH];
  int unsigned           list_len;
  logic [CFG_BITS-1:0]   cap_reg;
  logic [CFG_BITS-1:0]   grow_reg;
  list_result_t          pending_results[$];

  bit idle_en;
  int rx_hold;
  int err_count;
  int words_in;
  int results_checked;
  int cfg_writes;

  indexed_list_engine_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(64'd20_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic int unsigned list_capacity();
    if (grow_reg != '0) return DEPTH;
    return (cap_reg > DEPTH) ? DEPTH : cap_reg;
  endfunction

  function automatic list_result_t predict_list_op(input logic [47:0] w);
    logic [ACT_BITS-1:0]   act;
    logic [POS_BITS-1:0]   pos;
    logic [ENTRY_BITS-1:0] val;
    list_result_t          r;
    int unsigned           i;
    act      = w[2:0];
    pos      = w[9:3];
    val      = w[41:10];
    r.value  = '0;
    r.status = ST_OK;
    case (act)
      ACT_INSERT, ACT_PUSH: begin
        if (act == ACT_PUSH) pos = list_len[POS_BITS-1:0];
        if (pos > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= list_capacity()) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_len++;
          r.value = val;
        end
      end
      ACT_REMOVE, ACT_POP: begin
        if (act == ACT_POP) pos = (list_len == 0) ? '0 : POS_BITS'(list_len - 1);
        if (pos >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.value = list_mem[pos];
          for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      ACT_GET: begin
        if (pos >= list_len) r.status = ST_RANGE;
        else r.value = list_mem[pos];
      end
      ACT_SET: begin
        if (pos >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          list_mem[pos] = val;
          r.value = val;
        end
      end
      default: ;
    endcase
    r.length = list_len[CNT_BITS-1:0];
    r.empty  = (list_len == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      pending_results.push_back(predict_list_op(s_tdata));
      words_in++;
    end
  end

  always @(posedge clk) begin
    list_result_t got;
    list_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got.value  = m_tdata[31:0];
      got.status = m_tdata[33:32];
      got.length = m_tdata[40:34];
      got.empty  = m_tdata[41];
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result word %h", m_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        results_checked++;
        if (got.value !== exp_r.value || got.status !== exp_r.status ||
            got.length !== exp_r.length || got.empty !== exp_r.empty) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: exp val %h st %0d len %0d empty %0b / got val %h st %0d len %0d empty %0b",
                     exp_r.value, exp_r.status, exp_r.length, exp_r.empty,
                     got.value, got.status, got.length, got.empty);
        end
      end
    end
  end

  // sink side backpressure
  initial begin
    m_tready = 1'b0;
    rx_hold  = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        rx_hold = pick_gap();
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [ACT_BITS-1:0] act, input logic [POS_BITS-1:0] pos,
                           input logic [ENTRY_BITS-1:0] val);
    int gap;
    gap = idle_en ? pick_gap() : 0;
    repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, val, pos, act};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_INIT_CAP) cap_reg = val;
    else grow_reg = val;
    cfg_writes++;
  endtask

  function automatic logic [ACT_BITS-1:0] pick_action(input bit fill);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return (r < 3) ? ACT_NOP6 : ACT_NOP7;
    if (fill) begin
      if (r < 35) return ACT_INSERT;
      if (r < 60) return ACT_PUSH;
      if (r < 75) return ACT_GET;
      if (r < 85) return ACT_SET;
      if (r < 93) return ACT_REMOVE;
      return ACT_POP;
    end
    if (r < 13) return ACT_INSERT;
    if (r < 20) return ACT_PUSH;
    if (r < 35) return ACT_GET;
    if (r < 45) return ACT_SET;
    if (r < 75) return ACT_REMOVE;
    return ACT_POP;
  endfunction

  function automatic logic [POS_BITS-1:0] pick_pos();
    int unsigned r;
    int unsigned hint;
    hint = list_len;
    r = $urandom_range(0, 99);
    if (r < 80) return POS_BITS'($urandom_range(0, hint));
    if (r < 90) return POS_BITS'(hint + $urandom_range(0, 2));
    return POS_BITS'($urandom_range(0, 127));
  endfunction

  // reset register values; every range error path and every action on a short list
  task automatic test_directed_ops();
    send_word(ACT_POP,    7'd0,   32'h0000_0001);
    send_word(ACT_GET,    7'd0,   32'h0000_0000);
    send_word(ACT_REMOVE, 7'd0,   32'h0000_0000);
    send_word(ACT_SET,    7'd0,   32'hFFFF_FFFF);
    send_word(ACT_INSERT, 7'd1,   32'h0000_0001);
    send_word(ACT_INSERT, 7'd0,   32'hFFFF_FFFF);
    send_word(ACT_INSERT, 7'd0,   32'h0000_0000);
    send_word(ACT_INSERT, 7'd2,   32'hA5A5_A5A5);
    send_word(ACT_INSERT, 7'd1,   32'h5A5A_5A5A);
    send_word(ACT_PUSH,   7'd127, 32'h1234_5678);
    send_word(ACT_GET,    7'd0,   32'hFFFF_FFFF);
    send_word(ACT_GET,    7'd4,   32'h0000_0000);
    send_word(ACT_GET,    7'd5,   32'h0000_0000);
    send_word(ACT_SET,    7'd2,   32'hDEAD_BEEF);
    send_word(ACT_GET,    7'd127, 32'h0000_0000);
    send_word(ACT_INSERT, 7'd127, 32'h8000_0000);
    send_word(ACT_NOP6,   7'd127, 32'hFFFF_FFFF);
    send_word(ACT_NOP7,   7'd64,  32'h7FFF_FFFF);
    send_word(ACT_REMOVE, 7'd1,   32'h0000_0000);
    send_word(ACT_REMOVE, 7'd0,   32'h0000_0000);
    send_word(ACT_POP,    7'd0,   32'h0000_0000);
    send_word(ACT_GET,    7'd0,   32'h0000_0000);
    send_word(ACT_REMOVE, 7'd5,   32'h0000_0000);
  endtask

  // full list, capacity below the count, zero capacity, saturated capacity
  task automatic test_capacity_limits();
    wait_idle();
    write_reg(CFG_GROWTH, 7'd0);
    write_reg(CFG_INIT_CAP, 7'd2);
    while (list_len > 0) send_word(ACT_POP, 7'd0, 32'h0);
    send_word(ACT_PUSH,   7'd0, 32'h0000_00AA);
    send_word(ACT_PUSH,   7'd0, 32'h0000_00BB);
    send_word(ACT_PUSH,   7'd0, 32'h0000_00CC);
    send_word(ACT_INSERT, 7'd3, 32'h0000_00DD);
    send_word(ACT_INSERT, 7'd0, 32'h0000_00EE);
    wait_idle();
    write_reg(CFG_INIT_CAP, 7'd1);
    send_word(ACT_PUSH, 7'd0, 32'h1);
    send_word(ACT_POP,  7'd0, 32'h0);
    send_word(ACT_PUSH, 7'd0, 32'h2);
    send_word(ACT_POP,  7'd0, 32'h0);
    send_word(ACT_PUSH, 7'd0, 32'h3);
    wait_idle();
    write_reg(CFG_INIT_CAP, 7'd0);
    send_word(ACT_POP,    7'd0, 32'h0);
    send_word(ACT_INSERT, 7'd0, 32'h4);
    send_word(ACT_PUSH,   7'd0, 32'h5);
    wait_idle();
    write_reg(CFG_INIT_CAP, 7'd127);
    for (int k = 0; k < DEPTH; k++) send_word(ACT_PUSH, 7'd0, $urandom());
    send_word(ACT_PUSH,   7'd0,  32'h6);
    send_word(ACT_INSERT, 7'd64, 32'h7);
    send_word(ACT_INSERT, 7'd65, 32'h8);
    send_word(ACT_GET,    7'd63, 32'h0);
    send_word(ACT_REMOVE, 7'd63, 32'h0);
    wait_idle();
    write_reg(CFG_INIT_CAP, 7'd1);
    write_reg(CFG_GROWTH, 7'd64);
    send_word(ACT_PUSH, 7'd0, 32'h9);
    send_word(ACT_PUSH, 7'd0, 32'hA);
  endtask

  task automatic test_random_mix();
    int unsigned phase_cap[6]   = '{5, 64, 1, 100, 0, 0};
    int unsigned phase_grow[6]  = '{0, 0, 64, 0, 1, 0};
    int unsigned phase_items[6] = '{200, 250, 250, 200, 220, 80};
    bit          phase_idle[6]  = '{1, 1, 1, 0, 1, 1};
    bit          fill;
    int          run_left;
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_reg(CFG_INIT_CAP, CFG_BITS'(phase_cap[p]));
      write_reg(CFG_GROWTH, CFG_BITS'(phase_grow[p]));
      idle_en  = phase_idle[p];
      fill     = 1'b1;
      run_left = $urandom_range(20, 100);
      for (int k = 0; k < phase_items[p]; k++) begin
        if (run_left == 0) begin
          fill     = !fill;
          run_left = $urandom_range(20, 100);
        end
        run_left--;
        if (p == 1 && k == 120) wait_idle();  // let the result side empty out
        send_word(pick_action(fill), pick_pos(), $urandom());
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    rst             = 1'b1;
    s_tvalid        = 1'b0;
    s_tdata         = '0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_INIT_CAP;
    cfg_wdata       = '0;
    idle_en         = 1'b1;
    list_len        = 0;
    cap_reg         = INIT_CAP_RESET;
    grow_reg        = GROWTH_RESET;
    err_count       = 0;
    words_in        = 0;
    results_checked = 0;
    cfg_writes      = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_ops();
    test_capacity_limits();
    test_random_mix();
    wait_idle();

    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      err_count += pending_results.size();
    end
    $display("%0d words sent, %0d results checked, %0d register writes",
             words_in, results_checked, cfg_writes);
    $display("covered all actions, range and full errors, zero to saturated capacity");
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: indexed_list_engine_unit.f
hdl/ile_pkg.sv
hdl/ile_cell.sv
hdl/indexed_list_engine_unit.sv
tb/sv/tb.sv
